// ===== sv/jtdm_pkg.sv =====
// ----------------------------------------------------------------------------
// jtdm_pkg: shared types and constants of the tank drive mixer
// Widths, angle constants, arctangent table and register codes.
// ----------------------------------------------------------------------------
package jtdm_pkg;

	// default parameter values
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ANGLE_FRAC_DEF   = 13;

	// fixed field widths
	localparam int RAW_W  = 11;
	localparam int DB_W   = 10;
	localparam int ATT_W  = 13;
	localparam int CFG_DW = 13;
	localparam int CMD_W  = 13;
	localparam int SPD_W  = 8;

	// internal widths
	localparam int XW        = RAW_W + 1;      // centred stick axis
	localparam int SQ_W      = 2 * RAW_W + 1;  // x*x + y*y
	localparam int ROOT_BITS = 24;             // root of (x*x + y*y) << 24
	localparam int CW        = 32;             // cordic vector width
	localparam int PRESCALE  = 16;             // cordic input scaling
	localparam int BW        = 27;             // base vector, Q.12
	localparam int UNIT_FRAC = 12;             // Q.12 scaling
	localparam int CMD_SHIFT = 36;             // Q.36 to integer

	// pipeline depths
	localparam int MAX_STEPS = 24;             // rotation stages in cordic
	localparam int CORE_LAT  = MAX_STEPS + 1;  // cordic with its pre-rotation
	localparam int TAIL_LAT  = 7;
	localparam int LATENCY   = 1 + CORE_LAT + TAIL_LAT;

	// speed = |axis| / 10 via reciprocal
	localparam int SPD_MUL   = 3277;
	localparam int SPD_SHIFT = 15;

	// atan(2^-i) scaled by 2^30
	localparam longint ATAN30 [MAX_STEPS] = '{
		64'd843314857, 64'd497837829, 64'd263043837, 64'd133525159, 64'd67021687,
		64'd33543516, 64'd16775851, 64'd8388437, 64'd4194283, 64'd2097149,
		64'd1048576, 64'd524288, 64'd262144, 64'd131072, 64'd65536, 64'd32768,
		64'd16384, 64'd8192, 64'd4096, 64'd2048, 64'd1024, 64'd512, 64'd256, 64'd128
	};

	localparam longint HALF_PI_30  = 64'd1686629713;
	localparam longint SNAP0_30    = 64'd53687091;
	localparam longint SNAP_LIM_30 = 64'd3328599654;
	localparam longint PI_SET_30   = 64'd3373256577;
	localparam longint C157_30     = 64'd1685774664;

	// register indexes
	typedef enum logic [1:0] {
		REG_STICK_CENTER = 2'd0,
		REG_FIRE_DEADBAND = 2'd1,
		REG_MIN_ATT = 2'd2
	} cfg_reg_t;

	// monitor stick results
	typedef struct packed {
		logic             up;
		logic             down;
		logic             left;
		logic             right;
		logic [SPD_W-1:0] tilt;
		logic [SPD_W-1:0] pan;
	} mon_t;

	// round a 2^30 scaled angle to the angle format
	function automatic longint to_angle(longint v30, int frac);
		int s;
		s = 30 - frac;
		return (v30 + (longint'(1) << (s - 1))) >>> s;
	endfunction

endpackage

// ===== sv/jtdm_cordic.sv =====
// ----------------------------------------------------------------------------
// jtdm_cordic: pipelined vectoring cordic
// Gives atan2(x, y) from straight ahead; one stage per rotation.
// ----------------------------------------------------------------------------
module jtdm_cordic #(
	parameter int STEPS = jtdm_pkg::CORDIC_STEPS_DEF,
	parameter int FRAC  = jtdm_pkg::ANGLE_FRAC_DEF
) (
	input  logic                               clk,
	input  logic signed [jtdm_pkg::XW-1:0]     x,
	input  logic signed [jtdm_pkg::XW-1:0]     y,
	output logic signed [FRAC+2:0]             angle
);
	import jtdm_pkg::*;

	localparam int ZW = FRAC + 3;
	localparam logic signed [ZW-1:0] Z_HALF = ZW'(to_angle(HALF_PI_30, FRAC));

	logic signed [CW-1:0] cx_s [0:MAX_STEPS];
	logic signed [CW-1:0] cy_s [0:MAX_STEPS];
	logic signed [ZW-1:0] z_s  [0:MAX_STEPS];
	logic                 zero_s [0:MAX_STEPS];

	logic signed [CW-1:0] wx, wy, cx0, cy0;
	logic signed [ZW-1:0] z0;

	// pre-rotation into the right half plane
	always_comb begin
		wx  = CW'(y) <<< PRESCALE;
		wy  = CW'(x) <<< PRESCALE;
		cx0 = wx;
		cy0 = wy;
		z0  = '0;
		if (wx[CW-1]) begin
			if (!wy[CW-1]) begin
				cx0 = wy;
				cy0 = -wx;
				z0  = Z_HALF;
			end else begin
				cx0 = -wy;
				cy0 = wx;
				z0  = -Z_HALF;
			end
		end
	end

	always_ff @(posedge clk) begin
		cx_s[0]   <= cx0;
		cy_s[0]   <= cy0;
		z_s[0]    <= z0;
		zero_s[0] <= (x == '0) && (y == '0);
	end

	// rotation stages, unused ones pass through
	for (genvar i = 0; i < MAX_STEPS; i++) begin : g_stage
		localparam logic signed [ZW-1:0] DA = ZW'(to_angle(ATAN30[i], FRAC));
		if (i < STEPS) begin : g_rot
			always_ff @(posedge clk) begin
				if (!cy_s[i][CW-1]) begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					z_s[i+1]  <= z_s[i] + DA;
				end else begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					z_s[i+1]  <= z_s[i] - DA;
				end
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				cx_s[i+1] <= cx_s[i];
				cy_s[i+1] <= cy_s[i];
				z_s[i+1]  <= z_s[i];
			end
		end
		always_ff @(posedge clk) begin
			zero_s[i+1] <= zero_s[i];
		end
	end

	// centred stick gives angle zero
	assign angle = zero_s[MAX_STEPS] ? '0 : z_s[MAX_STEPS];

endmodule

// ===== sv/jtdm_isqrt.sv =====
// ----------------------------------------------------------------------------
// jtdm_isqrt: pipelined integer square root
// Root of (x*x + y*y) << 24, one result bit per stage.
// ----------------------------------------------------------------------------
module jtdm_isqrt (
	input  logic                              clk,
	input  logic [jtdm_pkg::SQ_W-1:0]         sum_sq,
	output logic [jtdm_pkg::ROOT_BITS-1:0]    root
);
	import jtdm_pkg::*;

	localparam int NW  = 2 * ROOT_BITS;
	localparam int RMW = ROOT_BITS + 2;
	localparam int TW  = RMW + 2;

	logic [ROOT_BITS-1:0] root_s [0:ROOT_BITS-1];
	logic [RMW-1:0]       rem_s  [0:ROOT_BITS-1];
	logic [NW-1:0]        n_s    [0:ROOT_BITS-1];

	for (genvar k = 0; k < ROOT_BITS; k++) begin : g_bit
		logic [ROOT_BITS-1:0] r_in;
		logic [RMW-1:0]       rem_in;
		logic [NW-1:0]        n_in;
		logic [TW-1:0]        trial, test;

		if (k == 0) begin : g_first
			assign r_in   = '0;
			assign rem_in = '0;
			assign n_in   = {{(NW-SQ_W-ROOT_BITS){1'b0}}, sum_sq, {ROOT_BITS{1'b0}}};
		end else begin : g_next
			assign r_in   = root_s[k-1];
			assign rem_in = rem_s[k-1];
			assign n_in   = n_s[k-1];
		end

		// trial subtract of 4r+1
		assign trial = {rem_in, n_in[NW-1:NW-2]};
		assign test  = {{(TW-ROOT_BITS-2){1'b0}}, r_in, 2'b01};

		always_ff @(posedge clk) begin
			n_s[k] <= n_in << 2;
			if (trial >= test) begin
				rem_s[k]  <= RMW'(trial - test);
				root_s[k] <= {r_in[ROOT_BITS-2:0], 1'b1};
			end else begin
				rem_s[k]  <= RMW'(trial);
				root_s[k] <= {r_in[ROOT_BITS-2:0], 1'b0};
			end
		end
	end

	assign root = root_s[ROOT_BITS-1];

endmodule

// ===== sv/joystick_tank_drive_mixer_unit.sv =====
// ----------------------------------------------------------------------------
// joystick_tank_drive_mixer_unit: stick frame to track and monitor commands
// Each frame runs from start to done through the pipeline; one frame accepted every cycle.
// The depth is set by the 24-stage cordic and square root plus the
// attenuation and double multiply tail; busy stays low, done is a strobe.
// Reset clears the valid pipeline and loads register defaults.
// ----------------------------------------------------------------------------
module joystick_tank_drive_mixer_unit #(
	parameter int CORDIC_STEPS    = jtdm_pkg::CORDIC_STEPS_DEF,
	parameter int ANGLE_FRAC_BITS = jtdm_pkg::ANGLE_FRAC_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [jtdm_pkg::RAW_W-1:0]       drive_x_raw,
	input  logic [jtdm_pkg::RAW_W-1:0]       drive_y_raw,
	input  logic [jtdm_pkg::RAW_W-1:0]       aim_x_raw,
	input  logic [jtdm_pkg::RAW_W-1:0]       aim_y_raw,
	input  logic                             cfg_write,
	input  logic [1:0]                       cfg_index,
	input  logic [jtdm_pkg::CFG_DW-1:0]      cfg_data,
	output logic                             done,
	output logic signed [jtdm_pkg::CMD_W-1:0] left_drive,
	output logic signed [jtdm_pkg::CMD_W-1:0] right_drive,
	output logic                             aim_up,
	output logic                             aim_down,
	output logic                             aim_left,
	output logic                             aim_right,
	output logic [jtdm_pkg::SPD_W-1:0]       tilt_speed,
	output logic [jtdm_pkg::SPD_W-1:0]       pan_speed
);
	import jtdm_pkg::*;

	localparam int F   = ANGLE_FRAC_BITS;
	localparam int ZW  = F + 3;
	localparam int AW  = F + 2;
	localparam int CFW = F + 1;
	localparam int QW  = 14;
	localparam int NQW = F + 15;
	localparam int PW  = BW + 2 * (ATT_W + 1);

	localparam logic [AW-1:0]  SNAP0_A  = AW'(to_angle(SNAP0_30, F));
	localparam logic [AW-1:0]  LIM_A    = AW'(to_angle(SNAP_LIM_30, F));
	localparam logic [AW-1:0]  PI_A     = AW'(to_angle(PI_SET_30, F));
	localparam longint         C157     = to_angle(C157_30, F);
	localparam longint         QR       = (longint'(1) << (F + 14)) / C157;
	localparam logic [CFW-1:0] C157_V   = CFW'(C157);
	localparam logic [QW-1:0]  QR_V     = QW'(QR);
	localparam logic [QW:0]    UNITY    = (QW+1)'(1 << UNIT_FRAC);

	// configuration registers
	logic [RAW_W-1:0] stick_center_q;
	logic [DB_W-1:0]  fire_deadband_q;
	logic [ATT_W-1:0] min_att_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stick_center_q  <= RAW_W'(1000);
			fire_deadband_q <= DB_W'(100);
			min_att_q       <= ATT_W'(1638);
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_STICK_CENTER:  stick_center_q  <= cfg_data[RAW_W-1:0];
				REG_FIRE_DEADBAND: fire_deadband_q <= cfg_data[DB_W-1:0];
				REG_MIN_ATT:       min_att_q       <= cfg_data[ATT_W-1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// valid pipeline
	logic [LATENCY-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LATENCY-2:0], start & ~busy};
		end
	end

	assign done = vld_q[LATENCY-1];

	// stage 1: centre the channels
	logic signed [XW-1:0] x_s1, y_s1, ax_s1, ay_s1;

	always_ff @(posedge clk) begin
		x_s1  <= signed'({1'b0, drive_x_raw}) - signed'({1'b0, stick_center_q});
		y_s1  <= signed'({1'b0, stick_center_q}) - signed'({1'b0, drive_y_raw});
		ax_s1 <= signed'({1'b0, aim_x_raw}) - signed'({1'b0, stick_center_q});
		ay_s1 <= signed'({1'b0, stick_center_q}) - signed'({1'b0, aim_y_raw});
	end

	// stage 2: squared radius and monitor stick
	logic signed [2*XW-1:0]       xx, yy;
	logic [2*XW-1:0]              sq_sum;
	logic [SQ_W-1:0]              sq_s2;
	logic [RAW_W-1:0]             ax_abs, ay_abs;
	logic [RAW_W+SPD_SHIFT-4:0]   tilt_p, pan_p;
	logic signed [XW-1:0]         db_pos, db_neg;
	mon_t                         mon_s2;

	always_comb begin
		xx     = x_s1 * x_s1;
		yy     = y_s1 * y_s1;
		sq_sum = unsigned'(xx) + unsigned'(yy);
		ax_abs = RAW_W'(ax_s1[XW-1] ? -ax_s1 : ax_s1);
		ay_abs = RAW_W'(ay_s1[XW-1] ? -ay_s1 : ay_s1);
		tilt_p = (RAW_W+SPD_SHIFT-3)'(ay_abs) * (RAW_W+SPD_SHIFT-3)'(SPD_MUL);
		pan_p  = (RAW_W+SPD_SHIFT-3)'(ax_abs) * (RAW_W+SPD_SHIFT-3)'(SPD_MUL);
		db_pos = signed'({2'b00, fire_deadband_q});
		db_neg = -db_pos;
	end

	always_ff @(posedge clk) begin
		sq_s2        <= sq_sum[SQ_W-1:0];
		mon_s2.up    <= ay_s1 > db_pos;
		mon_s2.down  <= ay_s1 < db_neg;
		mon_s2.left  <= ax_s1 < db_neg;
		mon_s2.right <= ax_s1 > db_pos;
		mon_s2.tilt  <= tilt_p[SPD_SHIFT+SPD_W-1:SPD_SHIFT];
		mon_s2.pan   <= pan_p[SPD_SHIFT+SPD_W-1:SPD_SHIFT];
	end

	// monitor results ride alongside the drive path
	mon_t mon_d [0:LATENCY-3];

	always_ff @(posedge clk) begin
		mon_d[0] <= mon_s2;
		for (int k = 1; k < LATENCY - 2; k++) begin
			mon_d[k] <= mon_d[k-1];
		end
	end

	assign aim_up     = mon_d[LATENCY-3].up;
	assign aim_down   = mon_d[LATENCY-3].down;
	assign aim_left   = mon_d[LATENCY-3].left;
	assign aim_right  = mon_d[LATENCY-3].right;
	assign tilt_speed = mon_d[LATENCY-3].tilt;
	assign pan_speed  = mon_d[LATENCY-3].pan;

	// centred axes delayed to meet the cordic result
	logic signed [XW-1:0] x_d [0:CORE_LAT-1];
	logic signed [XW-1:0] y_d [0:CORE_LAT-1];

	always_ff @(posedge clk) begin
		x_d[0] <= x_s1;
		y_d[0] <= y_s1;
		for (int k = 1; k < CORE_LAT; k++) begin
			x_d[k] <= x_d[k-1];
			y_d[k] <= y_d[k-1];
		end
	end

	// angle and magnitude units
	logic signed [ZW-1:0]   angle;
	logic [ROOT_BITS-1:0]   root;

	jtdm_cordic #(
		.STEPS (CORDIC_STEPS),
		.FRAC  (F)
	) u_cordic (
		.clk   (clk),
		.x     (x_s1),
		.y     (y_s1),
		.angle (angle)
	);

	jtdm_isqrt u_isqrt (
		.clk    (clk),
		.sum_sq (sq_s2),
		.root   (root)
	);

	// stage 27: snap the angle and pick the base vector
	logic [AW-1:0]        z_abs, mag_a;
	logic                 snap0, snappi;
	logic signed [BW-1:0] root_v;
	logic [AW-1:0]        mag_s27;
	logic signed [BW-1:0] bx_s27, by_s27;

	always_comb begin
		z_abs  = AW'(angle[ZW-1] ? -angle : angle);
		snap0  = z_abs < SNAP0_A;
		snappi = !snap0 && (z_abs > LIM_A);
		mag_a  = snap0 ? '0 : (snappi ? PI_A : z_abs);
		root_v = BW'(signed'({1'b0, root}));
	end

	always_ff @(posedge clk) begin
		mag_s27 <= mag_a;
		if (snap0) begin
			bx_s27 <= '0;
			by_s27 <= root_v;
		end else if (snappi) begin
			bx_s27 <= '0;
			by_s27 <= -root_v;
		end else begin
			bx_s27 <= BW'(x_d[CORE_LAT-1]) <<< UNIT_FRAC;
			by_s27 <= BW'(y_d[CORE_LAT-1]) <<< UNIT_FRAC;
		end
	end

	// stage 28: quotient estimate and track sums
	logic [AW+QW-1:0]     qe_prod;
	logic [QW-1:0]        e_s28;
	logic [AW-1:0]        mag_s28;
	logic signed [BW-1:0] sl_s28, sr_s28;

	assign qe_prod = (AW+QW)'(mag_s27) * (AW+QW)'(QR_V);

	always_ff @(posedge clk) begin
		e_s28   <= qe_prod[AW+QW-1:AW];
		mag_s28 <= mag_s27;
		sl_s28  <= by_s27 + bx_s27;
		sr_s28  <= by_s27 - bx_s27;
	end

	// stage 29: back-multiply the estimate
	logic [NQW-1:0]       ec_s29;
	logic [QW-1:0]        e_s29;
	logic [AW-1:0]        mag_s29;
	logic signed [BW-1:0] sl_s29, sr_s29;

	always_ff @(posedge clk) begin
		ec_s29  <= NQW'(e_s28) * NQW'(C157_V);
		e_s29   <= e_s28;
		mag_s29 <= mag_s28;
		sl_s29  <= sl_s28;
		sr_s29  <= sr_s28;
	end

	// stage 30: corrected quotient and attenuation
	logic [NQW-1:0]       rem_n;
	logic [QW:0]          q_full;
	logic [QW:0]          att_raw;
	logic [ATT_W-1:0]     att_s30;
	logic signed [BW-1:0] sl_s30, sr_s30;

	always_comb begin
		rem_n   = {1'b0, mag_s29, {UNIT_FRAC{1'b0}}} - ec_s29;
		q_full  = (rem_n >= NQW'(C157_V)) ? (QW+1)'(e_s29) + 1'b1 : (QW+1)'(e_s29);
		att_raw = (q_full > UNITY) ? q_full - UNITY : UNITY - q_full;
	end

	always_ff @(posedge clk) begin
		att_s30 <= (att_raw < (QW+1)'(min_att_q)) ? min_att_q : att_raw[ATT_W-1:0];
		sl_s30  <= sl_s29;
		sr_s30  <= sr_s29;
	end

	// stage 31: first attenuation product
	logic signed [ATT_W:0]        att_sx;
	logic signed [BW+ATT_W:0]     pl_s31, pr_s31;
	logic [ATT_W-1:0]             att_s31;

	assign att_sx = signed'({1'b0, att_s30});

	always_ff @(posedge clk) begin
		pl_s31  <= sl_s30 * att_sx;
		pr_s31  <= sr_s30 * att_sx;
		att_s31 <= att_s30;
	end

	// stage 32: second attenuation product
	logic signed [ATT_W:0] att_sx2;
	logic signed [PW-1:0]  pl_s32, pr_s32;

	assign att_sx2 = signed'({1'b0, att_s31});

	always_ff @(posedge clk) begin
		pl_s32 <= pl_s31 * att_sx2;
		pr_s32 <= pr_s31 * att_sx2;
	end

	// truncate toward zero and saturate
	function automatic logic signed [CMD_W-1:0] sat_cmd(logic signed [PW-1:0] p);
		logic [PW-1:0] mag;
		logic [PW-1:0] sh;
		logic          neg;
		neg = p[PW-1];
		mag = neg ? unsigned'(-p) : unsigned'(p);
		sh  = mag >> CMD_SHIFT;
		if (neg) begin
			if (sh >= PW'(1 << (CMD_W - 1))) begin
				sat_cmd = signed'({1'b1, {(CMD_W-1){1'b0}}});
			end else begin
				sat_cmd = -signed'(sh[CMD_W-1:0]);
			end
		end else begin
			if (sh >= PW'((1 << (CMD_W - 1)) - 1)) begin
				sat_cmd = signed'({1'b0, {(CMD_W-1){1'b1}}});
			end else begin
				sat_cmd = signed'(sh[CMD_W-1:0]);
			end
		end
	endfunction

	// stage 33: output registers
	logic signed [CMD_W-1:0] left_s33, right_s33;

	always_ff @(posedge clk) begin
		left_s33  <= sat_cmd(pl_s32);
		right_s33 <= sat_cmd(pr_s32);
	end

	assign left_drive  = left_s33;
	assign right_drive = right_s33;

endmodule

// ===== sv/jtdm_checker.sv =====
// ----------------------------------------------------------------------------
// jtdm_checker: port-level checks of the tank drive mixer
// Watches request timing and the monitor results.
// ----------------------------------------------------------------------------
module jtdm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input logic                            done,
	input logic                            aim_up,
	input logic                            aim_down,
	input logic                            aim_left,
	input logic                            aim_right,
	input logic [jtdm_pkg::SPD_W-1:0]      tilt_speed,
	input logic [jtdm_pkg::SPD_W-1:0]      pan_speed
);
	import jtdm_pkg::*;

	// every request comes out after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("request not answered after pipeline latency");

	// no result without a request
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without matching request");

	// up and down are exclusive
	a_vert_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(aim_up && aim_down))
		else $error("monitor up and down both raised");

	// left and right are exclusive
	a_horz_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(aim_left && aim_right))
		else $error("monitor left and right both raised");

	// speeds stay within a tenth of full deflection
	a_speed_rng: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (tilt_speed <= SPD_W'(204)) && (pan_speed <= SPD_W'(204)))
		else $error("monitor speed out of range");

endmodule

bind joystick_tank_drive_mixer_unit jtdm_checker u_jtdm_checker (.*);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for joystick_tank_drive_mixer_unit
// Stick frames come from a queue through a clocked driver with random gaps.
// A predictor computes the track and monitor commands of each accepted
// frame. A monitor compares every done strobe with the oldest prediction.
// Register settings change between phases, only while the pipeline is empty.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import jtdm_pkg::*;

	typedef struct packed {
		logic [RAW_W-1:0] dx;
		logic [RAW_W-1:0] dy;
		logic [RAW_W-1:0] ax;
		logic [RAW_W-1:0] ay;
	} frame_t;

	typedef struct packed {
		logic signed [CMD_W-1:0] left;
		logic signed [CMD_W-1:0] right;
		logic                    up;
		logic                    down;
		logic                    lf;
		logic                    rt;
		logic [SPD_W-1:0]        tilt;
		logic [SPD_W-1:0]        pan;
	} cmd_t;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int FRAME_W        = $bits(frame_t);

	logic clk, arst_n, start, busy, done;
	logic [RAW_W-1:0] drive_x_raw, drive_y_raw, aim_x_raw, aim_y_raw;
	logic cfg_write;
	logic [1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;
	logic signed [CMD_W-1:0] left_drive, right_drive;
	logic aim_up, aim_down, aim_left, aim_right;
	logic [SPD_W-1:0] tilt_speed, pan_speed;

	// register copies kept by the predictor
	longint center_q = 1000, deadband_q = 100, min_att_q = 1638;

	frame_t pending_frames[$];
	cmd_t   expected_cmds[$];
	int     frames_sent, cmds_seen, mismatches, idle_cycles;

	joystick_tank_drive_mixer_unit DUT (.*);

	// clock and reset
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
	end

	// rounding of 2^30 scaled constants to the angle format
	function automatic longint ang_q(longint v30);
		return (v30 + (longint'(1) << (29 - ANGLE_FRAC_DEF))) >>> (30 - ANGLE_FRAC_DEF);
	endfunction

	function automatic longint root_floor(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = longint'(1) << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return longint'(r);
	endfunction

	// track command: Q.36 product truncated toward zero and saturated
	function automatic logic signed [CMD_W-1:0] track_cmd(longint sum, longint att);
		longint p, m;
		p = sum * att * att;
		m = ((p < 0) ? -p : p) >>> CMD_SHIFT;
		if (m > 4096) m = 4096;
		if (p < 0) m = -m;
		if (m > 4095) m = 4095;
		return m[CMD_W-1:0];
	endfunction

	// expected commands of one stick frame
	function automatic cmd_t mix_frame(frame_t f);
		cmd_t r;
		longint x, y, ax, ay, a, mag_a, bx, by, q, att, m, cx, cy, t, sx, sy, da;
		int snap;
		x = longint'(f.dx) - center_q;
		y = center_q - longint'(f.dy);
		ax = longint'(f.ax) - center_q;
		ay = center_q - longint'(f.ay);
		// vectoring cordic with quadrant pre-rotation
		a = 0;
		if (x != 0 || y != 0) begin
			cx = y * 65536;
			cy = x * 65536;
			if (cx < 0) begin
				t = cx;
				if (cy >= 0) begin
					cx = cy; cy = -t; a = ang_q(HALF_PI_30);
				end else begin
					cx = -cy; cy = t; a = -ang_q(HALF_PI_30);
				end
			end
			for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
				sx = cy >>> i;
				sy = cx >>> i;
				da = ang_q(ATAN30[i]);
				if (cy >= 0) begin
					cx += sx; cy -= sy; a += da;
				end else begin
					cx -= sx; cy += sy; a -= da;
				end
			end
		end
		// snap near straight ahead and straight back
		snap = 0;
		bx = x * 4096;
		by = y * 4096;
		mag_a = (a < 0) ? -a : a;
		if (mag_a < ang_q(SNAP0_30)) begin
			a = 0; snap = 1;
		end
		mag_a = (a < 0) ? -a : a;
		if (mag_a > ang_q(SNAP_LIM_30)) begin
			a = ang_q(PI_SET_30); snap = 2;
		end
		mag_a = (a < 0) ? -a : a;
		if (snap != 0) begin
			m = root_floor(longint'(x * x + y * y) << 24);
			bx = 0;
			by = (snap == 1) ? m : -m;
		end
		// attenuation
		q = (mag_a * 4096) / ang_q(C157_30);
		att = 4096 - q;
		if (att < 0) att = -att;
		if (att < min_att_q) att = min_att_q;
		r.left  = track_cmd(by + bx, att);
		r.right = track_cmd(by - bx, att);
		r.up    = ay > deadband_q;
		r.down  = ay < -deadband_q;
		r.lf    = ax < -deadband_q;
		r.rt    = ax > deadband_q;
		r.tilt  = SPD_W'(((ay < 0) ? -ay : ay) / 10);
		r.pan   = SPD_W'(((ax < 0) ? -ax : ax) / 10);
		return r;
	endfunction

	// frame driver with random gaps, none in a middle stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 0;
			drive_x_raw <= '0;
			drive_y_raw <= '0;
			aim_x_raw <= '0;
			aim_y_raw <= '0;
			frames_sent <= 0;
		end else begin
			if (start && !busy) begin
				expected_cmds.push_back(mix_frame({drive_x_raw, drive_y_raw,
					aim_x_raw, aim_y_raw}));
				frames_sent <= frames_sent + 1;
			end
			if (!start || !busy) begin
				if (pending_frames.size() > 0 && !((frames_sent < 600 || frames_sent > 900)
						&& $urandom_range(99) < 33)) begin
					frame_t f;
					f = pending_frames.pop_front();
					drive_x_raw <= f.dx;
					drive_y_raw <= f.dy;
					aim_x_raw <= f.ax;
					aim_y_raw <= f.ay;
					start <= 1;
				end else begin
					start <= 0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			cmd_t got, want;
			got = {left_drive, right_drive, aim_up, aim_down, aim_left, aim_right,
				tilt_speed, pan_speed};
			cmds_seen <= cmds_seen + 1;
			if (expected_cmds.size() == 0) begin
				mismatches = mismatches + 1;
				if (mismatches <= 10) $display("unexpected result %h", got);
			end else begin
				want = expected_cmds.pop_front();
				if (got !== want) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10) begin
						$display("result %0d: exp L%0d R%0d u%b d%b l%b r%b t%0d p%0d",
							cmds_seen, want.left, want.right, want.up, want.down,
							want.lf, want.rt, want.tilt, want.pan);
						$display("result %0d: got L%0d R%0d u%b d%b l%b r%b t%0d p%0d",
							cmds_seen, got.left, got.right, got.up, got.down,
							got.lf, got.rt, got.tilt, got.pan);
					end
				end
			end
		end
	end

	// watchdog on cycles without any request or result
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("joystick_tank_drive_mixer_unit: mismatch");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [CFG_DW-1:0] val);
		@(posedge clk);
		cfg_write <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 0;
		case (idx)
			REG_STICK_CENTER:  center_q = longint'(val[RAW_W-1:0]);
			REG_FIRE_DEADBAND: deadband_q = longint'(val[DB_W-1:0]);
			REG_MIN_ATT:       min_att_q = longint'(val);
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_frames.size() > 0 || expected_cmds.size() > 0 || start)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	function automatic logic [RAW_W-1:0] clip(longint v);
		if (v < 0) return '0;
		if (v > 2047) return '1;
		return v[RAW_W-1:0];
	endfunction

	// directed frames around the current centre and deadband
	task automatic push_directed();
		longint c, d;
		c = center_q;
		d = deadband_q;
		pending_frames.push_back({11'd0, 11'd0, 11'd0, 11'd0});
		pending_frames.push_back({11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF});
		pending_frames.push_back({11'd0, 11'h7FF, 11'h7FF, 11'd0});
		pending_frames.push_back({11'h7FF, 11'd0, 11'd0, 11'h7FF});
		pending_frames.push_back({clip(c), clip(c), clip(c), clip(c)});
		pending_frames.push_back({clip(c), clip(c - 600), clip(c + d), clip(c - d)});
		pending_frames.push_back({clip(c), clip(c + 600), clip(c - d), clip(c + d)});
		pending_frames.push_back({clip(c + 500), clip(c), clip(c + d + 1), clip(c - d - 1)});
		pending_frames.push_back({clip(c - 500), clip(c), clip(c - d - 1), clip(c + d + 1)});
		pending_frames.push_back({clip(c + 20), clip(c - 800), clip(c + 2047), clip(c - 2047)});
		pending_frames.push_back({clip(c - 30), clip(c + 800), clip(c - 2047), clip(c + 2047)});
		pending_frames.push_back({clip(c + 400), clip(c - 400), clip(c), clip(c)});
		pending_frames.push_back({clip(c - 400), clip(c + 400), clip(c + 9), clip(c - 10)});
		pending_frames.push_back({clip(c + 1), clip(c), clip(c + 11), clip(c - 19)});
	endtask

	// random frames: uniform, near centre, and near the snap angles
	task automatic push_random(int n);
		frame_t f;
		longint c;
		c = center_q;
		repeat (n) begin
			f = FRAME_W'({$urandom, $urandom});
			case ($urandom_range(3))
				1: begin
					f.dx = clip(c + $urandom_range(40) - 20);
					f.dy = clip(c + $urandom_range(40) - 20);
				end
				2: begin
					f.dx = clip(c + $urandom_range(80) - 40);
					f.dy = clip(c + (($urandom_range(1) == 1) ? 1 : -1)
						* longint'($urandom_range(1500, 300)));
				end
				default: ;
			endcase
			pending_frames.push_back(f);
		end
	endtask

	task automatic run_phase(int n);
		push_directed();
		push_random(n);
		drain();
	endtask

	initial begin
		cfg_write = 0;
		cfg_index = REG_STICK_CENTER;
		cfg_data = '0;
		mismatches = 0;
		cmds_seen = 0;
		idle_cycles = 0;
		wait (arst_n);
		repeat (3) @(posedge clk);
		// register defaults after reset
		run_phase(360);
		// low extremes
		write_reg(REG_STICK_CENTER, 13'd0);
		write_reg(REG_FIRE_DEADBAND, 13'd0);
		write_reg(REG_MIN_ATT, 13'd0);
		run_phase(300);
		// high extremes
		write_reg(REG_STICK_CENTER, 13'd2047);
		write_reg(REG_FIRE_DEADBAND, 13'd1023);
		write_reg(REG_MIN_ATT, 13'd4096);
		run_phase(300);
		// mid settings, unused register index included
		write_reg(REG_STICK_CENTER, 13'd1024);
		write_reg(REG_FIRE_DEADBAND, 13'd37);
		write_reg(REG_MIN_ATT, 13'd900);
		write_reg(2'd3, CFG_DW'($urandom));
		run_phase(300);
		// random settings
		write_reg(REG_STICK_CENTER, CFG_DW'($urandom_range(1800, 200)));
		write_reg(REG_FIRE_DEADBAND, CFG_DW'($urandom_range(1023)));
		write_reg(REG_MIN_ATT, CFG_DW'($urandom_range(4096)));
		run_phase(300);
		$display("ran %0d frames over five register settings, %0d results checked",
			frames_sent, cmds_seen);
		$display("%0d mismatches", mismatches);
		if (mismatches == 0 && expected_cmds.size() == 0)
			$display("joystick_tank_drive_mixer_unit: match");
		else
			$display("joystick_tank_drive_mixer_unit: mismatch");
		$finish;
	end
endmodule
